// File: hw/rtl/fsmc_pkg.sv
// Shared opcodes, binary64 constants and operand-property type for the FP64 misc unit.
package fsmc_pkg;

   // Operation codes
   localparam logic [3:0] OP_SGNJ  = 4'd0;
   localparam logic [3:0] OP_SGNJN = 4'd1;
   localparam logic [3:0] OP_SGNJX = 4'd2;
   localparam logic [3:0] OP_MIN   = 4'd3;
   localparam logic [3:0] OP_MAX   = 4'd4;
   localparam logic [3:0] OP_EQ    = 4'd5;
   localparam logic [3:0] OP_LT    = 4'd6;
   localparam logic [3:0] OP_LE    = 4'd7;
   localparam logic [3:0] OP_CLASS = 4'd8;

   // binary64 layout
   localparam int unsigned EXP_W  = 11;
   localparam int unsigned FRAC_W = 52;
   localparam int unsigned CLS_W  = 10;
   localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

   // Class mask bit positions
   localparam logic [3:0] CLS_NEG_INF  = 4'd0;
   localparam logic [3:0] CLS_NEG_NORM = 4'd1;
   localparam logic [3:0] CLS_NEG_SUB  = 4'd2;
   localparam logic [3:0] CLS_NEG_ZERO = 4'd3;
   localparam logic [3:0] CLS_POS_ZERO = 4'd4;
   localparam logic [3:0] CLS_POS_SUB  = 4'd5;
   localparam logic [3:0] CLS_POS_NORM = 4'd6;
   localparam logic [3:0] CLS_POS_INF  = 4'd7;
   localparam logic [3:0] CLS_SNAN     = 4'd8;
   localparam logic [3:0] CLS_QNAN     = 4'd9;

   // Properties of one operand
   typedef struct packed {
      logic             sign;
      logic             nan;
      logic             snan;
      logic             zero;
      logic [CLS_W-1:0] cls;
   } opnd_info_type;

endpackage

// File: hw/rtl/fsmc_opnd_decode.sv
// Decodes one binary64 operand into NaN, zero, sign and class-mask properties.
module fsmc_opnd_decode (
   input  logic [63:0]            operand,
   output fsmc_pkg::opnd_info_type info
);

   logic [fsmc_pkg::EXP_W-1:0]  exp_field;
   logic [fsmc_pkg::FRAC_W-1:0] frac_field;
   logic                        exp_ones;
   logic                        exp_zero;
   logic                        frac_zero;
   logic                        quiet;
   logic                        neg;

   assign exp_field  = operand[62:52];
   assign frac_field = operand[51:0];
   assign exp_ones   = &exp_field;
   assign exp_zero   = ~|exp_field;
   assign frac_zero  = ~|frac_field;
   assign quiet      = operand[51];
   assign neg        = operand[63];

   // Property and class decode
   always_comb begin
      info      = '0;
      info.sign = neg;
      info.nan  = exp_ones & ~frac_zero;
      info.snan = exp_ones & ~frac_zero & ~quiet;
      info.zero = exp_zero & frac_zero;
      if (exp_ones) begin
         if (frac_zero) begin
            info.cls[neg ? fsmc_pkg::CLS_NEG_INF : fsmc_pkg::CLS_POS_INF] = 1'b1;
         end else begin
            info.cls[quiet ? fsmc_pkg::CLS_QNAN : fsmc_pkg::CLS_SNAN] = 1'b1;
         end
      end else if (exp_zero) begin
         if (frac_zero) begin
            info.cls[neg ? fsmc_pkg::CLS_NEG_ZERO : fsmc_pkg::CLS_POS_ZERO] = 1'b1;
         end else begin
            info.cls[neg ? fsmc_pkg::CLS_NEG_SUB : fsmc_pkg::CLS_POS_SUB] = 1'b1;
         end
      end else begin
         info.cls[neg ? fsmc_pkg::CLS_NEG_NORM : fsmc_pkg::CLS_POS_NORM] = 1'b1;
      end
   end

endmodule

// File: hw/rtl/fp64_sign_minmax_compare_class.sv
// Top level of the FP64 sign-injection, min/max, compare and classify unit.
//
//   Channel | Direction | Ports
//   --------+-----------+--------------------------------------------------
//   req     | in        | req_valid, req_ready, req_opcode, req_operand_a/b
//   rsp     | out       | rsp_valid, rsp_ready, rsp_result, rsp_invalid_flag
//
// Three register stages: operand decode plus low-half magnitude compare,
// high-half compare merge, then result select into the output register.
// One request per cycle is sustained while rsp_ready stays high.
// Each stage loads when it is empty or the stage after it moves, so a
// stall on rsp_ready holds every stage in place and bubbles are squeezed.
// Synchronous active-high reset clears only the stage valid bits.
module fp64_sign_minmax_compare_class (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result,
   output logic        rsp_invalid_flag
);

   // Stage advance chain
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_adv, s2_adv, s3_adv;

   assign s3_adv    = ~s3_valid_ff | rsp_ready;
   assign s2_adv    = ~s2_valid_ff | s3_adv;
   assign s1_adv    = ~s1_valid_ff | s2_adv;
   assign req_ready = s1_adv;

   // Stage 1: decode operands, compare low magnitude half
   fsmc_pkg::opnd_info_type info_a, info_b;

   fsmc_opnd_decode u_dec_a (.operand(req_operand_a), .info(info_a));
   fsmc_opnd_decode u_dec_b (.operand(req_operand_b), .info(info_b));

   logic [3:0]              s1_op_ff;
   logic [63:0]             s1_a_ff, s1_b_ff;
   fsmc_pkg::opnd_info_type s1_ia_ff, s1_ib_ff;
   logic                    s1_lo_lt_ff, s1_lo_eq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_adv) begin
         s1_op_ff    <= req_opcode;
         s1_a_ff     <= req_operand_a;
         s1_b_ff     <= req_operand_b;
         s1_ia_ff    <= info_a;
         s1_ib_ff    <= info_b;
         s1_lo_lt_ff <= req_operand_a[31:0] < req_operand_b[31:0];
         s1_lo_eq_ff <= req_operand_a[31:0] == req_operand_b[31:0];
      end
   end

   // Stage 2: merge high half into full magnitude compare (bits 62..0)
   logic                    hi_lt, hi_eq;
   logic [3:0]              s2_op_ff;
   logic [63:0]             s2_a_ff, s2_b_ff;
   fsmc_pkg::opnd_info_type s2_ia_ff, s2_ib_ff;
   logic                    s2_mag_lt_ff, s2_mag_eq_ff;

   assign hi_lt = s1_a_ff[62:32] < s1_b_ff[62:32];
   assign hi_eq = s1_a_ff[62:32] == s1_b_ff[62:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_adv) begin
         s2_op_ff     <= s1_op_ff;
         s2_a_ff      <= s1_a_ff;
         s2_b_ff      <= s1_b_ff;
         s2_ia_ff     <= s1_ia_ff;
         s2_ib_ff     <= s1_ib_ff;
         s2_mag_lt_ff <= hi_lt | (hi_eq & s1_lo_lt_ff);
         s2_mag_eq_ff <= hi_eq & s1_lo_eq_ff;
      end
   end

   // Stage 3: order relations and result select
   logic        mag_gt, sign_diff;
   logic        a_lt_b, b_lt_a;        // total order, -0 below +0
   logic        both_zero, any_nan, any_snan;
   logic        num_lt, num_eq;
   logic [63:0] result_in;
   logic        invalid_in;
   logic [63:0] s3_result_ff;
   logic        s3_invalid_ff;

   assign mag_gt    = ~s2_mag_lt_ff & ~s2_mag_eq_ff;
   assign sign_diff = s2_ia_ff.sign ^ s2_ib_ff.sign;
   assign a_lt_b    = sign_diff ? s2_ia_ff.sign : (s2_ia_ff.sign ? mag_gt : s2_mag_lt_ff);
   assign b_lt_a    = sign_diff ? s2_ib_ff.sign : (s2_ia_ff.sign ? s2_mag_lt_ff : mag_gt);
   assign both_zero = s2_ia_ff.zero & s2_ib_ff.zero;
   assign any_nan   = s2_ia_ff.nan | s2_ib_ff.nan;
   assign any_snan  = s2_ia_ff.snan | s2_ib_ff.snan;
   assign num_lt    = a_lt_b & ~both_zero;
   assign num_eq    = (~sign_diff & s2_mag_eq_ff) | both_zero;

   always_comb begin
      result_in  = '0;
      invalid_in = 1'b0;
      unique case (s2_op_ff)
         fsmc_pkg::OP_SGNJ: begin
            result_in = {s2_b_ff[63], s2_a_ff[62:0]};
         end
         fsmc_pkg::OP_SGNJN: begin
            result_in = {~s2_b_ff[63], s2_a_ff[62:0]};
         end
         fsmc_pkg::OP_SGNJX: begin
            result_in = {s2_a_ff[63] ^ s2_b_ff[63], s2_a_ff[62:0]};
         end
         fsmc_pkg::OP_MIN, fsmc_pkg::OP_MAX: begin
            invalid_in = any_snan;
            if (s2_ia_ff.nan & s2_ib_ff.nan) begin
               result_in = fsmc_pkg::CANON_NAN;
            end else if (s2_ia_ff.nan) begin
               result_in = s2_b_ff;
            end else if (s2_ib_ff.nan) begin
               result_in = s2_a_ff;
            end else if (s2_op_ff == fsmc_pkg::OP_MIN) begin
               result_in = a_lt_b ? s2_a_ff : s2_b_ff;
            end else begin
               result_in = b_lt_a ? s2_a_ff : s2_b_ff;
            end
         end
         fsmc_pkg::OP_EQ: begin
            invalid_in = any_snan;
            result_in  = {63'd0, ~any_nan & num_eq};
         end
         fsmc_pkg::OP_LT: begin
            invalid_in = any_nan;
            result_in  = {63'd0, ~any_nan & num_lt};
         end
         fsmc_pkg::OP_LE: begin
            invalid_in = any_nan;
            result_in  = {63'd0, ~any_nan & (num_lt | num_eq)};
         end
         fsmc_pkg::OP_CLASS: begin
            result_in = {{(64 - fsmc_pkg::CLS_W){1'b0}}, s2_ia_ff.cls};
         end
         default: begin
            result_in  = '0;
            invalid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_adv) begin
         s3_result_ff  <= result_in;
         s3_invalid_ff <= invalid_in;
      end
   end

   assign rsp_valid        = s3_valid_ff;
   assign rsp_result       = s3_result_ff;
   assign rsp_invalid_flag = s3_invalid_ff;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the FP64 sign-injection, min/max, compare and classify unit.
`timescale 1ns / 100ps

module testbench;

   // Highest value of the 4-bit opcode field; codes above OP_CLASS are unused
   localparam logic [3:0] OP_TOP_CODE = 4'hF;

   // Handy binary64 patterns for the directed requests
   localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
   localparam logic [63:0] POS_ONE  = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] NEG_ONE  = 64'hBFF0_0000_0000_0000;
   localparam logic [63:0] POS_TWO  = 64'h4000_0000_0000_0000;
   localparam logic [63:0] NEG_TWO  = 64'hC000_0000_0000_0000;
   localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] SIG_NAN  = 64'h7FF0_0000_0000_0001;
   localparam logic [63:0] POS_SUB  = 64'h0000_0000_0000_0001;
   localparam logic [63:0] NEG_SUB  = 64'h800F_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int unsigned HOLD_CYCLES  = 80;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam longint unsigned LIMIT_NS = 3_000_000;

   typedef struct {
      logic [3:0]  opcode;
      logic [63:0] result;
      logic        invalid_flag;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_opcode = fsmc_pkg::OP_SGNJ;
   logic [63:0] req_operand_a = '0;
   logic [63:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_result;
   logic        rsp_invalid_flag;

   outcome_type pending_outcomes[$];
   bit          sender_idle = 1'b0;
   bit          receiver_idle = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned checked_count = 0;
   int unsigned request_count = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned nan_operand_count = 0;
   int unsigned op_count[16];

   fp64_sign_minmax_compare_class uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result       (rsp_result),
      .rsp_invalid_flag (rsp_invalid_flag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Operand properties and the expected-outcome calculation
   // ---------------------------------------------------------------
   function automatic bit is_nan(input logic [63:0] x);
      return (&x[62:52]) && (|x[51:0]);
   endfunction

   function automatic bit is_snan(input logic [63:0] x);
      return is_nan(x) && !x[51];
   endfunction

   function automatic bit is_zero(input logic [63:0] x);
      return x[62:0] == '0;
   endfunction

   // Strict order on non-NaN patterns, -0 below +0
   function automatic bit ordered_below(input logic [63:0] a, input logic [63:0] b);
      if (a[63] != b[63])
         return a[63];
      return a[63] ? (a > b) : (a < b);
   endfunction

   // Numeric less-than: the two zeros are equal
   function automatic bit value_below(input logic [63:0] a, input logic [63:0] b);
      if (is_zero(a) && is_zero(b))
         return 1'b0;
      return ordered_below(a, b);
   endfunction

   function automatic bit same_value(input logic [63:0] a, input logic [63:0] b);
      return (a == b) || (is_zero(a) && is_zero(b));
   endfunction

   function automatic logic [63:0] class_mask(input logic [63:0] x);
      logic [fsmc_pkg::CLS_W-1:0] mask;
      mask = '0;
      if (&x[62:52]) begin
         if (x[51:0] == '0)
            mask[x[63] ? fsmc_pkg::CLS_NEG_INF : fsmc_pkg::CLS_POS_INF] = 1'b1;
         else
            mask[x[51] ? fsmc_pkg::CLS_QNAN : fsmc_pkg::CLS_SNAN] = 1'b1;
      end else if (x[62:52] == '0) begin
         if (x[51:0] == '0)
            mask[x[63] ? fsmc_pkg::CLS_NEG_ZERO : fsmc_pkg::CLS_POS_ZERO] = 1'b1;
         else
            mask[x[63] ? fsmc_pkg::CLS_NEG_SUB : fsmc_pkg::CLS_POS_SUB] = 1'b1;
      end else begin
         mask[x[63] ? fsmc_pkg::CLS_NEG_NORM : fsmc_pkg::CLS_POS_NORM] = 1'b1;
      end
      return {{(64 - fsmc_pkg::CLS_W){1'b0}}, mask};
   endfunction

   function automatic outcome_type predict_outcome(input logic [3:0] op, input logic [63:0] a,
                                                   input logic [63:0] b);
      outcome_type o;
      bit a_nan;
      bit b_nan;
      bit any_snan;
      a_nan = is_nan(a);
      b_nan = is_nan(b);
      any_snan = is_snan(a) || is_snan(b);
      o.opcode = op;
      o.result = '0;
      o.invalid_flag = 1'b0;
      case (op)
         fsmc_pkg::OP_SGNJ:  o.result = {b[63], a[62:0]};
         fsmc_pkg::OP_SGNJN: o.result = {~b[63], a[62:0]};
         fsmc_pkg::OP_SGNJX: o.result = {a[63] ^ b[63], a[62:0]};
         fsmc_pkg::OP_MIN, fsmc_pkg::OP_MAX: begin
            o.invalid_flag = any_snan;
            if (a_nan && b_nan)
               o.result = fsmc_pkg::CANON_NAN;
            else if (a_nan)
               o.result = b;
            else if (b_nan)
               o.result = a;
            else if (op == fsmc_pkg::OP_MIN)
               o.result = ordered_below(a, b) ? a : b;
            else
               o.result = ordered_below(b, a) ? a : b;
         end
         fsmc_pkg::OP_EQ: begin
            o.invalid_flag = any_snan;
            o.result[0] = !a_nan && !b_nan && same_value(a, b);
         end
         fsmc_pkg::OP_LT, fsmc_pkg::OP_LE: begin
            // ordered compares signal on any NaN
            if (a_nan || b_nan)
               o.invalid_flag = 1'b1;
            else if (op == fsmc_pkg::OP_LT)
               o.result[0] = value_below(a, b);
            else
               o.result[0] = value_below(a, b) || same_value(a, b);
         end
         fsmc_pkg::OP_CLASS: o.result = class_mask(a);
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Random stimulus helpers
   // ---------------------------------------------------------------
   // Mostly no gap, some short ones, a few long ones
   function automatic int unsigned draw_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [3:0] random_opcode();
      if ($urandom_range(0, 9) == 0)
         return 4'($urandom_range(fsmc_pkg::OP_CLASS + 1, OP_TOP_CODE));
      return 4'($urandom_range(fsmc_pkg::OP_SGNJ, fsmc_pkg::OP_CLASS));
   endfunction

   // Biased toward the interesting classes; raw patterns cover every bit
   function automatic logic [63:0] random_operand();
      logic [63:0] raw;
      logic        s;
      logic [51:0] f;
      raw = {$urandom, $urandom};
      s = raw[63];
      f = raw[51:0];
      case ($urandom_range(0, 9))
         0: return {s, 63'd0};
         1: return {s, 11'd0, (f == '0) ? 52'd1 : f};
         2: return {s, 11'h7FF, 52'd0};
         3: return {s, 11'h7FF, 1'b1, f[50:0]};
         4: return {s, 11'h7FF, 1'b0, (f[50:0] == '0) ? 51'd1 : f[50:0]};
         5, 6: return {s, 11'($urandom_range(1, 2046)), f};
         default: return raw;
      endcase
   endfunction

   // Second operand close to the first so compares hit ties and neighbors
   function automatic logic [63:0] partner_operand(input logic [63:0] a);
      case ($urandom_range(0, 9))
         0, 1: return a;
         2: return a + 64'd1;
         3: return a - 64'd1;
         4: return {~a[63], a[62:0]};
         5: return {a[63:52], 52'($urandom_range(0, 3))};
         default: return random_operand();
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Request driver: holds valid and payload until accepted
   // ---------------------------------------------------------------
   task automatic send_request(input logic [3:0] op, input logic [63:0] a,
                               input logic [63:0] b);
      int unsigned gap;
      gap = sender_idle ? draw_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) begin
         input_stall_cycles++;
         @(posedge clock);
      end
      pending_outcomes.push_back(predict_outcome(op, a, b));
      request_count++;
      op_count[op]++;
      nan_operand_count += is_nan(a) + is_nan(b);
   endtask

   task automatic send_random_request();
      logic [63:0] a;
      a = random_operand();
      send_request(random_opcode(), a, partner_operand(a));
   endtask

   // ---------------------------------------------------------------
   // Response side: random backpressure plus a long hold on request
   // ---------------------------------------------------------------
   initial begin
      int unsigned gap;
      forever begin
         gap = receiver_idle ? draw_gap() : 0;
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare every accepted response with the oldest prediction
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: response with nothing outstanding: result %h invalid %b",
                        $realtime, rsp_result, rsp_invalid_flag);
         end else begin
            want = pending_outcomes.pop_front();
            checked_count++;
            if (rsp_result !== want.result || rsp_invalid_flag !== want.invalid_flag) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: op %0d mismatch: result exp %h got %h, invalid exp %b got %b",
                           $realtime, want.opcode, want.result, rsp_result,
                           want.invalid_flag, rsp_invalid_flag);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_sign_injection();
      send_request(fsmc_pkg::OP_SGNJ, ALL_ONES, POS_ZERO);
      send_request(fsmc_pkg::OP_SGNJN, POS_ZERO, ALL_ONES);
      send_request(fsmc_pkg::OP_SGNJX, NEG_ONE, NEG_TWO);
   endtask

   task automatic test_min_max();
      send_request(fsmc_pkg::OP_MIN, POS_ZERO, NEG_ZERO);
      send_request(fsmc_pkg::OP_MAX, NEG_ZERO, POS_ZERO);
      send_request(fsmc_pkg::OP_MIN, fsmc_pkg::CANON_NAN, POS_ONE);  // one quiet NaN
      send_request(fsmc_pkg::OP_MAX, POS_TWO, SIG_NAN);       // signaling NaN raises invalid
      send_request(fsmc_pkg::OP_MIN, fsmc_pkg::CANON_NAN, SIG_NAN);  // both NaN: canonical
   endtask

   task automatic test_compares();
      send_request(fsmc_pkg::OP_EQ, POS_ZERO, NEG_ZERO);
      send_request(fsmc_pkg::OP_EQ, fsmc_pkg::CANON_NAN, fsmc_pkg::CANON_NAN);  // no invalid
      send_request(fsmc_pkg::OP_EQ, SIG_NAN, POS_ONE);
      send_request(fsmc_pkg::OP_LT, fsmc_pkg::CANON_NAN, POS_ONE);  // ordered: invalid
      send_request(fsmc_pkg::OP_LE, NEG_ZERO, POS_ZERO);
      send_request(fsmc_pkg::OP_LT, NEG_INF, POS_INF);
   endtask

   task automatic test_classify();
      send_request(fsmc_pkg::OP_CLASS, NEG_INF, ALL_ONES);
      send_request(fsmc_pkg::OP_CLASS, NEG_ONE, POS_ZERO);
      send_request(fsmc_pkg::OP_CLASS, NEG_SUB, POS_ZERO);
      send_request(fsmc_pkg::OP_CLASS, NEG_ZERO, POS_ZERO);
      send_request(fsmc_pkg::OP_CLASS, POS_ZERO, POS_ZERO);
      send_request(fsmc_pkg::OP_CLASS, POS_SUB, POS_ZERO);
      send_request(fsmc_pkg::OP_CLASS, POS_ONE, POS_ZERO);
      send_request(fsmc_pkg::OP_CLASS, POS_INF, POS_ZERO);
      send_request(fsmc_pkg::OP_CLASS, SIG_NAN, POS_ZERO);
      send_request(fsmc_pkg::OP_CLASS, fsmc_pkg::CANON_NAN, POS_ZERO);
   endtask

   task automatic test_unused_code();
      send_request(OP_TOP_CODE, ALL_ONES, ALL_ONES);
   endtask

   task automatic test_random_mix(input int unsigned count);
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
      repeat (count) send_random_request();
   endtask

   // Receiver holds off while requests keep coming, so the pipe fills up
   task automatic test_backpressure(input int unsigned count);
      sender_idle = 1'b0;
      hold_request = 1'b1;
      repeat (count) send_random_request();
      while (hold_request) @(posedge clock);
   endtask

   task automatic test_back_to_back(input int unsigned count);
      sender_idle = 1'b0;
      receiver_idle = 1'b0;
      repeat (count) send_random_request();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sign_injection();
      test_min_max();
      test_compares();
      test_classify();
      test_unused_code();
      test_random_mix(400);
      test_backpressure(30);
      test_back_to_back(200);

      req_valid <= 1'b0;
      receiver_idle = 1'b1;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d unused-code, %0d NaN operands), checked %0d responses.",
               request_count, request_count - op_count[fsmc_pkg::OP_SGNJ]
               - op_count[fsmc_pkg::OP_SGNJN] - op_count[fsmc_pkg::OP_SGNJX]
               - op_count[fsmc_pkg::OP_MIN] - op_count[fsmc_pkg::OP_MAX]
               - op_count[fsmc_pkg::OP_EQ] - op_count[fsmc_pkg::OP_LT]
               - op_count[fsmc_pkg::OP_LE] - op_count[fsmc_pkg::OP_CLASS],
               nan_operand_count, checked_count);
      $display("Request side stalled %0d cycles under response backpressure; %0d mismatches.",
               input_stall_cycles, mismatch_count);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_NS);
      $display("Timed out with %0d responses outstanding.", pending_outcomes.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
